>>> rtl/core/scle_pkg.sv
`timescale 1ns / 1ps

package scle_pkg;

  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CMD_LEN_W = 5;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ECHO,
    ST_RD,
    ST_WT
  } state_e;

  typedef enum logic [1:0] {
    ECHO_CHAR,
    ECHO_BS,
    ECHO_NL
  } echo_kind_e;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic [7:0]           data;
    logic [CMD_LEN_W-1:0] len;
    logic                 last;
  } emit_t;

  typedef struct packed {
    logic cmd_inc;
    logic ovr_inc;
  } ev_t;

endpackage

>>> rtl/core/scle_ram.sv
`timescale 1ns / 1ps

module scle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/scle_ctrl.sv
`timescale 1ns / 1ps

module scle_ctrl #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          in_stall_o,
  input  logic                          echo_enable_i,
  output logic                          ram_we_o,
  output logic [$clog2(LINE_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(LINE_DEPTH)-1:0] ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i,
  output scle_pkg::emit_t               emit_o,
  input  logic                          emit_ready_i,
  output scle_pkg::ev_t                 ev_o
);

  import scle_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

  state_e     state_q, state_d;
  echo_kind_e kind_q, kind_d;
  logic [1:0]    idx_q, idx_d;
  logic [7:0]    char_q, char_d;
  logic [AW-1:0] fill_q, fill_d;
  logic          prev_cr_q, prev_cr_d;
  logic          cmd_q, cmd_d;
  logic [AW-1:0] scan_addr_q, scan_addr_d;
  logic          chk_q, chk_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;
  logic          found_q, found_d;
  logic [AW-1:0] first_q, first_d;
  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;

  logic [7:0]    echo_data;
  logic          echo_final;
  logic [LW-1:0] cmd_len;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  always_comb begin
    unique case (kind_q)
      ECHO_CHAR: begin
        echo_data  = char_q;
        echo_final = 1'b1;
      end
      ECHO_BS: begin
        echo_data  = (idx_q == 2'd1) ? CH_SP : CH_BS;
        echo_final = (idx_q == 2'd2);
      end
      ECHO_NL: begin
        echo_data  = (idx_q == 2'd0) ? CH_CR : CH_LF;
        echo_final = (idx_q == 2'd1);
      end
      default: begin
        echo_data  = char_q;
        echo_final = 1'b1;
      end
    endcase
  end

  assign cmd_len    = {1'b0, last_q} - {1'b0, first_q} + LW'(1);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    char_d      = char_q;
    fill_d      = fill_q;
    prev_cr_d   = prev_cr_q;
    cmd_d       = cmd_q;
    scan_addr_d = scan_addr_q;
    chk_d       = chk_q;
    chk_idx_d   = chk_idx_q;
    found_d     = found_q;
    first_d     = first_q;
    last_d      = last_q;
    rd_ptr_d    = rd_ptr_q;
    emit_o      = '0;
    ev_o        = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q;
    ram_wdata_o = rx_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          char_d = rx_byte_i;
          cmd_d  = 1'b0;
          idx_d  = 2'd0;
          priority if (rx_byte_i == CH_BS || rx_byte_i == CH_DEL) begin
            prev_cr_d = 1'b0;
            if (fill_q != '0) begin
              fill_d = fill_q - AW'(1);
              if (echo_enable_i) begin
                kind_d  = ECHO_BS;
                state_d = ST_ECHO;
              end
            end
          end else if (rx_byte_i == CH_LF && prev_cr_q) begin
            prev_cr_d = 1'b0;
          end else if (rx_byte_i == CH_CR || rx_byte_i == CH_LF) begin
            prev_cr_d   = (rx_byte_i == CH_CR);
            scan_addr_d = '0;
            chk_d       = 1'b0;
            found_d     = 1'b0;
            state_d     = ST_SCAN;
          end else begin
            prev_cr_d = 1'b0;
            if (fill_q < FILL_MAX) begin
              ram_we_o = 1'b1;
              fill_d   = fill_q + AW'(1);
            end else begin
              ev_o.ovr_inc = 1'b1;
            end
            if (echo_enable_i) begin
              kind_d  = ECHO_CHAR;
              state_d = ST_ECHO;
            end
          end
        end
      end

      ST_SCAN: begin
        if (scan_addr_q < fill_q) begin
          ram_re_o    = 1'b1;
          scan_addr_d = scan_addr_q + AW'(1);
          chk_d       = 1'b1;
          chk_idx_d   = scan_addr_q;
        end else begin
          chk_d = 1'b0;
        end
        if (chk_q) begin
          if (!is_blank(ram_rdata_i)) begin
            if (!found_q) begin
              first_d = chk_idx_q;
            end
            last_d  = chk_idx_q;
            found_d = 1'b1;
          end
        end else if (scan_addr_q == fill_q) begin
          ev_o.cmd_inc = found_q;
          cmd_d        = found_q;
          fill_d       = '0;
          rd_ptr_d     = first_q;
          idx_d        = 2'd0;
          kind_d       = ECHO_NL;
          if (echo_enable_i) begin
            state_d = ST_ECHO;
          end else if (found_q) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_ECHO: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_ECHO;
        emit_o.data  = echo_data;
        emit_o.last  = echo_final && !cmd_q;
        if (emit_ready_i) begin
          if (echo_final) begin
            state_d = cmd_q ? ST_RD : ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end

      ST_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = rd_ptr_q;
        state_d     = ST_WT;
      end

      ST_WT: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_CMD;
        emit_o.data  = ram_rdata_i;
        emit_o.len   = CMD_LEN_W'(cmd_len);
        emit_o.last  = (rd_ptr_q == last_q);
        if (emit_ready_i) begin
          if (rd_ptr_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
            state_d  = ST_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      prev_cr_q <= 1'b0;
      chk_q     <= 1'b0;
      found_q   <= 1'b0;
      cmd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      prev_cr_q <= prev_cr_d;
      chk_q     <= chk_d;
      found_q   <= found_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    idx_q       <= idx_d;
    char_q      <= char_d;
    scan_addr_q <= scan_addr_d;
    chk_idx_q   <= chk_idx_d;
    first_q     <= first_d;
    last_q      <= last_d;
    rd_ptr_q    <= rd_ptr_d;
  end

endmodule

>>> rtl/core/serial_command_line_editor_unit.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------------
// input     | in_valid_i / in_stall_o   | rx_byte_i
// output    | out_valid_o / out_stall_i | out_kind_o, out_byte_o, command_length_o,
//           |                           | last_o, commands_received_o, overrun_count_o
// config    | cfg_we_i                  | cfg_wdata_i (echo enable)
//
// One request at a time; in_stall_o is high from acceptance until its last result is
// loaded into the output register. A plain byte is taken, then echoed if echo is enabled.
// A line end is taken, then the line store is scanned (one read port, one entry a
// cycle), then CR LF is echoed and the command bytes are sent (registered read).
// Reset clears control state and the counters; echo enable resets to 1.
// out_stall_i holds the output register; the sequencer waits while it is full and stalled.
`timescale 1ns / 1ps

module serial_command_line_editor_unit #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         rx_byte_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               out_kind_o,
  output logic [7:0]                         out_byte_o,
  output logic [scle_pkg::CMD_LEN_W-1:0]     command_length_o,
  output logic                               last_o,
  output logic [scle_pkg::CNT_W-1:0]         commands_received_o,
  output logic [scle_pkg::CNT_W-1:0]         overrun_count_o
);

  import scle_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  logic             echo_q;
  logic [CNT_W-1:0] cmd_cnt_q, ovr_cnt_q;
  logic             out_valid_q;
  logic             out_kind_q;
  logic [7:0]       out_byte_q;
  logic [CMD_LEN_W-1:0] out_len_q;
  logic             out_last_q;
  logic [CNT_W-1:0] out_cmd_q, out_ovr_q;

  logic          out_free;
  emit_t         emit;
  ev_t           ev;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  scle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scle_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .rx_byte_i     (rx_byte_i),
    .in_stall_o    (in_stall_o),
    .echo_enable_i (echo_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .emit_o        (emit),
    .emit_ready_i  (out_free),
    .ev_o          (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q      <= 1'b1;
      cmd_cnt_q   <= '0;
      ovr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        echo_q <= cfg_wdata_i;
      end
      if (ev.cmd_inc) begin
        cmd_cnt_q <= cmd_cnt_q + CNT_W'(1);
      end
      if (ev.ovr_inc && (ovr_cnt_q != '1)) begin
        ovr_cnt_q <= ovr_cnt_q + CNT_W'(1);
      end
      if (out_free) begin
        out_valid_q <= emit.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_kind_q <= emit.kind;
      out_byte_q <= emit.data;
      out_len_q  <= emit.len;
      out_last_q <= emit.last;
      out_cmd_q  <= cmd_cnt_q;
      out_ovr_q  <= ovr_cnt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_byte_o          = out_byte_q;
  assign command_length_o    = out_len_q;
  assign last_o              = out_last_q;
  assign commands_received_o = out_cmd_q;
  assign overrun_count_o     = out_ovr_q;

endmodule

>>> rtl/core/scle_chk.sv
`timescale 1ns / 1ps

module scle_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [7:0]                     rx_byte_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           out_kind_o,
  input logic [7:0]                     out_byte_o,
  input logic [scle_pkg::CMD_LEN_W-1:0] command_length_o,
  input logic                           last_o
);

  import scle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output request changed");

  a_echo_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_ECHO) |-> command_length_o == '0)
    else $error("echo request carries a command length");

  a_cr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (rx_byte_i == CH_CR) |=> in_stall_o)
    else $error("carriage return did not start a line scan");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken before all results of a request were issued");

endmodule

bind serial_command_line_editor_unit scle_chk u_scle_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .rx_byte_i        (rx_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_kind_o       (out_kind_o),
  .out_byte_o       (out_byte_o),
  .command_length_o (command_length_o),
  .last_o           (last_o)
);
